@@ hw/rtl/rgta_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgta_pkg
// Shared types and constants of the RDS group text assembler.
// ----------------------------------------------------------------------------
package rgta_pkg;

	localparam int STORE_DEPTH = 208;
	localparam int ADDR_W      = 8;

	localparam logic [7:0] BASE_NAME = 8'd0;
	localparam logic [7:0] BASE_RT   = 8'd8;
	localparam logic [7:0] BASE_TN   = 8'd72;
	localparam logic [7:0] BASE_ERT  = 8'd80;

	localparam logic [15:0] AID_TAGGING  = 16'h4bd7;
	localparam logic [15:0] AID_ENHANCED = 16'h6552;
	localparam logic [7:0]  CHAR_CR      = 8'h0d;

	localparam logic [3:0] GT_NAME = 4'd0;
	localparam logic [3:0] GT_RT   = 4'd2;
	localparam logic [3:0] GT_ODA  = 4'd3;
	localparam logic [3:0] GT_TN   = 4'd10;

	localparam logic [2:0] STAT_IGNORED   = 3'd0;
	localparam logic [2:0] STAT_BUFFERED  = 3'd1;
	localparam logic [2:0] STAT_CONFIRMED = 3'd2;
	localparam logic [2:0] STAT_RESTARTED = 3'd3;
	localparam logic [2:0] STAT_COMPLETE  = 3'd4;
	localparam logic [2:0] STAT_EMPTY     = 3'd5;
	localparam logic [2:0] STAT_APP_REG   = 3'd6;

	localparam logic [1:0] KIND_NAME = 2'd0;
	localparam logic [1:0] KIND_RT   = 2'd1;
	localparam logic [1:0] KIND_TN   = 2'd2;
	localparam logic [1:0] KIND_ERT  = 2'd3;

	typedef enum logic [4:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_EMIT,
		ST_RX_RD,
		ST_RX_EV,
		ST_CF_RD,
		ST_CF_EV,
		ST_MASK,
		ST_WIPE,
		ST_REFILL,
		ST_POST,
		ST_SCAN_RD,
		ST_SCAN_EV,
		ST_FULL_CHK,
		ST_OUT_RD0,
		ST_OUT_RD1,
		ST_OUT_EV,
		ST_OUT_EMIT
	} state_t;

endpackage

@@ hw/rtl/rgta_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgta_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module rgta_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

@@ hw/rtl/rds_group_text_assembler.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rds_group_text_assembler
// Assembles service name, RadioText, type name and enhanced RadioText from
// RDS groups, confirming each segment on a second identical copy.
// ----------------------------------------------------------------------------
// A text group is checked byte by byte against the receive RAM and then the
// confirmed RAM; a restart wipes a RadioText or enhanced RadioText, a
// carriage-return scan may mark a text complete early, and a complete text is
// read out in byte pairs. One group at a time; the byte-wide receive and
// confirmed RAMs set the pace. After reset both RAMs are cleared, during
// which no request is taken.
module rds_group_text_assembler
	import rgta_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        grp_valid,
	output logic        grp_stall,
	input  logic [15:0] block_b,
	input  logic [15:0] block_c,
	input  logic [15:0] block_d,
	output logic        res_valid,
	input  logic        res_stall,
	output logic [2:0]  status,
	output logic [1:0]  text_kind,
	output logic [4:0]  segment_number,
	output logic [15:0] text_pair,
	output logic [5:0]  pair_index,
	output logic        last
);

	state_t state_q, state_d;

	logic [3:0]  name_seen_q;
	logic [15:0] rt_seen_q;
	logic [1:0]  tn_seen_q;
	logic [31:0] ert_seen_q;
	logic [3:0]  tag_gt_q;
	logic        tag_tmpl_q;
	logic [3:0]  ert_gt_q;
	logic [2:0]  ert_table_q;
	logic        ert_utf8_q;

	logic [1:0]  kind_q;
	logic [4:0]  seg_q;
	logic        bpc4_q;
	logic [7:0]  len_q;
	logic [7:0]  base_q;
	logic        wide_q;
	logic        long_q;
	logic [7:0]  bytes_q [4];
	logic [1:0]  idx_q;
	logic        same_q;
	logic        restart_q;
	logic [7:0]  scan_q;
	logic [5:0]  pair_cnt_q;
	logic [7:0]  hi_q;
	logic [7:0]  lo_q;
	logic [2:0]  em_status_q;

	logic        res_valid_q;
	logic [2:0]  status_q;
	logic [1:0]  kind_out_q;
	logic [4:0]  seg_out_q;
	logic [15:0] pair_out_q;
	logic [5:0]  idx_out_q;
	logic        last_q;

	logic        rx_we, cf_we;
	logic [7:0]  rx_waddr, cf_waddr, rx_raddr, cf_raddr;
	logic [7:0]  rx_wdata, cf_wdata, rx_rdata, cf_rdata;

	// decode of the request at the input
	logic [3:0]  gt;
	logic        vb;
	logic        dec_text, dec_tag_set, dec_ert_set;
	logic [1:0]  dec_kind;
	logic [4:0]  dec_seg;
	logic        dec_bpc4, dec_wide, dec_long;
	logic [7:0]  dec_len, dec_base;
	logic [7:0]  dec_bytes [4];
	logic [2:0]  dec_status;
	logic [3:0]  agt;

	logic        accept, out_free, load_res;
	logic [6:0]  off;
	logic [7:0]  seg_addr, pair_addr;
	logic        seg_end, byte_diff_rx, byte_diff_cf;
	logic [31:0] cur_mask, full_mask, flag;
	logic        hit;
	logic        mask_we;
	logic [31:0] mask_wd;
	logic [7:0]  scan_nxt;
	logic        scan_brk, scan_cr, scan_done;
	logic        is_empty;
	logic [5:0]  last_pair;
	logic        out_last;

	assign gt  = block_b[15:12];
	assign vb  = block_b[11];
	assign agt = block_b[4:1];

	always_comb begin
		dec_text    = 1'b0;
		dec_tag_set = 1'b0;
		dec_ert_set = 1'b0;
		dec_kind    = KIND_NAME;
		dec_seg     = 5'd0;
		dec_bpc4    = 1'b1;
		dec_wide    = 1'b0;
		dec_long    = 1'b0;
		dec_len     = 8'd8;
		dec_base    = BASE_NAME;
		dec_status  = STAT_IGNORED;
		dec_bytes[0] = block_c[15:8];
		dec_bytes[1] = block_c[7:0];
		dec_bytes[2] = block_d[15:8];
		dec_bytes[3] = block_d[7:0];
		priority if (gt == GT_NAME) begin
			dec_text     = 1'b1;
			dec_seg      = {3'd0, block_b[1:0]};
			dec_bpc4     = 1'b0;
			dec_bytes[0] = block_d[15:8];
			dec_bytes[1] = block_d[7:0];
		end else if (gt == GT_RT) begin
			dec_text = 1'b1;
			dec_kind = KIND_RT;
			dec_seg  = {1'b0, block_b[3:0]};
			dec_base = BASE_RT;
			dec_long = 1'b1;
			if (vb) begin
				dec_bpc4     = 1'b0;
				dec_len      = 8'd32;
				dec_bytes[0] = block_d[15:8];
				dec_bytes[1] = block_d[7:0];
			end else begin
				dec_len = 8'd64;
			end
		end else if (gt == GT_ODA && !vb) begin
			if (block_d == AID_TAGGING && tag_gt_q != agt) begin
				dec_tag_set = 1'b1;
				dec_status  = STAT_APP_REG;
			end else if (block_d == AID_ENHANCED && ert_gt_q != agt) begin
				dec_ert_set = 1'b1;
				dec_status  = STAT_APP_REG;
			end
		end else if (gt == GT_TN && !vb) begin
			dec_text = 1'b1;
			dec_kind = KIND_TN;
			dec_seg  = {4'd0, block_b[0]};
			dec_base = BASE_TN;
		end else if (gt == GT_ODA || gt == GT_TN || vb) begin
			dec_text = 1'b0;
		end else if (gt == tag_gt_q && !tag_tmpl_q) begin
			dec_text = 1'b0;
		end else if (gt == ert_gt_q && ert_table_q == 3'd0) begin
			dec_text = 1'b1;
			dec_kind = KIND_ERT;
			dec_seg  = block_b[4:0];
			dec_base = BASE_ERT;
			dec_len  = 8'd128;
			dec_long = 1'b1;
			dec_wide = !ert_utf8_q;
		end
	end

	// datapath helpers
	assign off       = bpc4_q ? {seg_q, 2'b00} : {1'b0, seg_q, 1'b0};
	assign seg_addr  = 8'(base_q + {1'b0, off} + {6'd0, idx_q});
	assign pair_addr = 8'(base_q + {1'b0, pair_cnt_q, (state_q == ST_OUT_RD1)});
	assign seg_end   = (idx_q == (bpc4_q ? 2'd3 : 2'd1));
	assign byte_diff_rx = (rx_rdata != bytes_q[idx_q]);
	assign byte_diff_cf = (cf_rdata != bytes_q[idx_q]);
	assign flag      = 32'd1 << seg_q;
	assign last_pair = 6'(len_q[7:1] - 7'd1);
	assign out_last  = (pair_cnt_q == last_pair);
	assign out_free  = !res_valid_q || !res_stall;
	assign accept    = grp_valid && !grp_stall;

	always_comb begin
		unique case (kind_q)
			KIND_NAME: begin
				cur_mask  = {28'd0, name_seen_q};
				full_mask = 32'h0000000f;
			end
			KIND_RT: begin
				cur_mask  = {16'd0, rt_seen_q};
				full_mask = 32'h0000ffff;
			end
			KIND_TN: begin
				cur_mask  = {30'd0, tn_seen_q};
				full_mask = 32'h00000003;
			end
			default: begin
				cur_mask  = ert_seen_q;
				full_mask = 32'hffffffff;
			end
		endcase
	end
	assign hit = |(cur_mask & flag);

	always_comb begin
		scan_brk = 1'b0;
		scan_cr  = 1'b0;
		scan_nxt = 8'(scan_q + 8'd1);
		if (wide_q && !scan_q[0]) begin
			if (cf_rdata != 8'd0) begin
				scan_nxt = 8'(scan_q + 8'd2);
			end
		end else begin
			scan_brk = (cf_rdata == 8'd0);
			scan_cr  = (cf_rdata == CHAR_CR);
		end
		scan_done = scan_brk || scan_cr || (scan_nxt >= len_q);
	end

	assign is_empty = wide_q ? (hi_q == 8'd0 && (cf_rdata == 8'd0 || cf_rdata == CHAR_CR))
	                         : (hi_q == 8'd0 || hi_q == CHAR_CR);

	// sequencer
	always_comb begin
		state_d   = state_q;
		grp_stall = 1'b1;
		rx_we     = 1'b0;
		cf_we     = 1'b0;
		rx_waddr  = seg_addr;
		cf_waddr  = seg_addr;
		rx_wdata  = bytes_q[idx_q];
		cf_wdata  = bytes_q[idx_q];
		rx_raddr  = seg_addr;
		cf_raddr  = seg_addr;
		mask_we   = 1'b0;
		mask_wd   = (hit ? 32'd0 : cur_mask) | flag;
		load_res  = 1'b0;
		unique case (state_q)
			ST_CLEAR: begin
				rx_we    = 1'b1;
				cf_we    = 1'b1;
				rx_waddr = scan_q;
				cf_waddr = scan_q;
				rx_wdata = 8'd0;
				cf_wdata = 8'd0;
				if (scan_q == 8'(STORE_DEPTH - 1)) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				grp_stall = 1'b0;
				if (grp_valid) begin
					state_d = dec_text ? ST_RX_RD : ST_EMIT;
				end
			end
			ST_EMIT: begin
				if (out_free) begin
					load_res = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			ST_RX_RD: state_d = ST_RX_EV;
			ST_RX_EV: begin
				rx_we = byte_diff_rx;
				if (!seg_end) begin
					state_d = ST_RX_RD;
				end else if (same_q && !byte_diff_rx) begin
					state_d = ST_CF_RD;
				end else begin
					state_d = ST_EMIT;
				end
			end
			ST_CF_RD: state_d = ST_CF_EV;
			ST_CF_EV: begin
				cf_we   = byte_diff_cf;
				state_d = seg_end ? ST_MASK : ST_CF_RD;
			end
			ST_MASK: begin
				if (hit && same_q) begin
					state_d = ST_EMIT;
				end else begin
					mask_we = 1'b1;
					state_d = (hit && long_q) ? ST_WIPE : ST_POST;
				end
			end
			ST_WIPE: begin
				cf_we    = 1'b1;
				cf_waddr = 8'(base_q + scan_q);
				cf_wdata = 8'd0;
				if (scan_q == 8'(len_q - 8'd1)) begin
					state_d = ST_REFILL;
				end
			end
			ST_REFILL: begin
				cf_we = 1'b1;
				if (seg_end) begin
					state_d = ST_POST;
				end
			end
			ST_POST: begin
				state_d = (cur_mask != full_mask && long_q) ? ST_SCAN_RD : ST_FULL_CHK;
			end
			ST_SCAN_RD: begin
				cf_raddr = 8'(base_q + scan_q);
				state_d  = ST_SCAN_EV;
			end
			ST_SCAN_EV: begin
				mask_we = scan_cr;
				mask_wd = full_mask;
				state_d = scan_done ? ST_FULL_CHK : ST_SCAN_RD;
			end
			ST_FULL_CHK: begin
				state_d = (cur_mask == full_mask) ? ST_OUT_RD0 : ST_EMIT;
			end
			ST_OUT_RD0: begin
				cf_raddr = pair_addr;
				state_d  = ST_OUT_RD1;
			end
			ST_OUT_RD1: begin
				cf_raddr = pair_addr;
				state_d  = ST_OUT_EV;
			end
			ST_OUT_EV: begin
				state_d = (pair_cnt_q == 6'd0 && is_empty) ? ST_EMIT : ST_OUT_EMIT;
			end
			ST_OUT_EMIT: begin
				if (out_free) begin
					load_res = 1'b1;
					state_d  = out_last ? ST_IDLE : ST_OUT_RD0;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	// control state: masks and announcement registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			name_seen_q <= '0;
			rt_seen_q   <= '0;
			tn_seen_q   <= '0;
			ert_seen_q  <= '0;
			tag_gt_q    <= '0;
			tag_tmpl_q  <= 1'b0;
			ert_gt_q    <= '0;
			ert_table_q <= '0;
			ert_utf8_q  <= 1'b0;
			scan_q      <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (mask_we) begin
				unique case (kind_q)
					KIND_NAME: name_seen_q <= mask_wd[3:0];
					KIND_RT:   rt_seen_q   <= mask_wd[15:0];
					KIND_TN:   tn_seen_q   <= mask_wd[1:0];
					default:   ert_seen_q  <= mask_wd;
				endcase
			end
			if (accept && dec_tag_set) begin
				tag_gt_q   <= agt;
				tag_tmpl_q <= block_c[12];
			end
			if (accept && dec_ert_set) begin
				ert_gt_q    <= agt;
				ert_table_q <= block_c[4:2];
				ert_utf8_q  <= block_c[0];
			end
			if (state_q == ST_CLEAR || state_q == ST_WIPE) begin
				scan_q <= 8'(scan_q + 8'd1);
			end else if (state_q == ST_POST || state_q == ST_MASK) begin
				scan_q <= '0;
			end else if (state_q == ST_SCAN_EV) begin
				scan_q <= scan_nxt;
			end
			if (load_res) begin
				res_valid_q <= 1'b1;
			end else if (!res_stall) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	// working registers of the current request
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					kind_q      <= dec_kind;
					seg_q       <= dec_seg;
					bpc4_q      <= dec_bpc4;
					len_q       <= dec_len;
					base_q      <= dec_base;
					wide_q      <= dec_wide;
					long_q      <= dec_long;
					bytes_q     <= dec_bytes;
					idx_q       <= '0;
					same_q      <= 1'b1;
					restart_q   <= 1'b0;
					em_status_q <= dec_status;
				end
			end
			ST_RX_EV: begin
				if (byte_diff_rx) begin
					same_q <= 1'b0;
				end
				if (!seg_end) begin
					idx_q <= 2'(idx_q + 2'd1);
				end else if (same_q && !byte_diff_rx) begin
					idx_q <= '0;
				end else begin
					em_status_q <= STAT_BUFFERED;
				end
			end
			ST_CF_EV: begin
				if (byte_diff_cf) begin
					same_q <= 1'b0;
				end
				idx_q <= 2'(idx_q + 2'd1);
			end
			ST_MASK: begin
				em_status_q <= STAT_IGNORED;
				restart_q   <= hit;
				idx_q       <= '0;
			end
			ST_REFILL: idx_q <= 2'(idx_q + 2'd1);
			ST_FULL_CHK: begin
				pair_cnt_q  <= '0;
				em_status_q <= restart_q ? STAT_RESTARTED : STAT_CONFIRMED;
			end
			ST_OUT_RD1: hi_q <= cf_rdata;
			ST_OUT_EV: begin
				lo_q        <= cf_rdata;
				em_status_q <= STAT_EMPTY;
			end
			ST_OUT_EMIT: begin
				if (out_free) begin
					pair_cnt_q <= 6'(pair_cnt_q + 6'd1);
				end
			end
			default: begin
			end
		endcase
		if (load_res) begin
			kind_out_q <= kind_q;
			seg_out_q  <= seg_q;
			if (state_q == ST_OUT_EMIT) begin
				status_q   <= STAT_COMPLETE;
				pair_out_q <= {hi_q, lo_q};
				idx_out_q  <= pair_cnt_q;
				last_q     <= out_last;
			end else begin
				status_q   <= em_status_q;
				pair_out_q <= '0;
				idx_out_q  <= '0;
				last_q     <= 1'b1;
			end
		end
	end

	rgta_ram #(.WIDTH(8), .DEPTH(STORE_DEPTH)) u_rx_ram (
		.clk   (clk),
		.we    (rx_we),
		.waddr (rx_waddr),
		.wdata (rx_wdata),
		.raddr (rx_raddr),
		.rdata (rx_rdata)
	);

	rgta_ram #(.WIDTH(8), .DEPTH(STORE_DEPTH)) u_cf_ram (
		.clk   (clk),
		.we    (cf_we),
		.waddr (cf_waddr),
		.wdata (cf_wdata),
		.raddr (cf_raddr),
		.rdata (cf_rdata)
	);

	assign res_valid      = res_valid_q;
	assign status         = status_q;
	assign text_kind      = kind_out_q;
	assign segment_number = seg_out_q;
	assign text_pair      = pair_out_q;
	assign pair_index     = idx_out_q;
	assign last           = last_q;

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> grp_stall)
		else $error("request taken while another is in work");

	a_no_take_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_CLEAR |-> grp_stall)
		else $error("request taken during RAM clear");

	a_midtext_complete: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q && !last_q |-> status_q == STAT_COMPLETE)
		else $error("non-final result without complete status");

	a_index_only_complete: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q && idx_out_q != 6'd0 |-> status_q == STAT_COMPLETE)
		else $error("pair index on a non-readout result");

endmodule

@@ tb/rgta_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgta_checker
// Watches the group and result channels of the RDS group text assembler,
// predicts the result rows of every accepted group and compares them in order.
// ----------------------------------------------------------------------------
module rgta_checker
	import rgta_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        grp_valid,
	input  logic        grp_stall,
	input  logic [15:0] block_b,
	input  logic [15:0] block_c,
	input  logic [15:0] block_d,
	input  logic        res_valid,
	input  logic        res_stall,
	input  logic [2:0]  status,
	input  logic [1:0]  text_kind,
	input  logic [4:0]  segment_number,
	input  logic [15:0] text_pair,
	input  logic [5:0]  pair_index,
	input  logic        last,
	output int          fail_count,
	output int          rows_pending
);

	typedef struct packed {
		logic [2:0]  st;
		logic [1:0]  kind;
		logic [4:0]  seg;
		logic [15:0] pair;
		logic [5:0]  idx;
		logic        lst;
	} row_t;

	row_t rows_due[$];

	// all four texts share one byte space, laid out as the block's RAM
	logic [7:0]  rx_mem [0:207];
	logic [7:0]  cf_mem [0:207];
	logic [31:0] seen [0:3];
	logic [3:0]  tag_gt;
	logic        tag_tmpl;
	logic [3:0]  ert_gt;
	logic [2:0]  ert_table;
	logic        ert_utf8;

	assign rows_pending = rows_due.size();

	function automatic row_t mk_row(logic [2:0] st, logic [1:0] kind, logic [4:0] seg,
			logic [15:0] pair, logic [5:0] idx, logic lst);
		row_t r;
		r.st = st; r.kind = kind; r.seg = seg; r.pair = pair; r.idx = idx; r.lst = lst;
		return r;
	endfunction

	task automatic assemble_segment(int kind, int base, int seg, int bpc, int total,
			bit wide, logic [7:0] b0, logic [7:0] b1, logic [7:0] b2, logic [7:0] b3);
		logic [7:0] by [0:3];
		int off, len, pairs;
		bit same, restarted, empty;
		logic [31:0] flag, full;
		logic [7:0] ch;
		by[0] = b0; by[1] = b1; by[2] = b2; by[3] = b3;
		off = base + seg * bpc;
		len = bpc * total;
		flag = 32'd1 << seg;
		full = (total == 32) ? 32'hffff_ffff : (32'd1 << total) - 32'd1;
		same = 1;
		restarted = 0;
		for (int i = 0; i < bpc; i++)
			if (rx_mem[off + i] != by[i]) begin
				rx_mem[off + i] = by[i];
				same = 0;
			end
		if (!same) begin
			rows_due.push_back(mk_row(STAT_BUFFERED, 2'(kind), 5'(seg), 16'd0, 6'd0, 1'b1));
			return;
		end
		for (int i = 0; i < bpc; i++)
			if (cf_mem[off + i] != rx_mem[off + i]) begin
				cf_mem[off + i] = rx_mem[off + i];
				same = 0;
			end
		if (seen[kind] & flag) begin
			if (same) begin
				rows_due.push_back(mk_row(STAT_IGNORED, 2'(kind), 5'(seg), 16'd0, 6'd0,
					1'b1));
				return;
			end
			restarted = 1;
			seen[kind] = 0;
			if (total > 4) begin
				for (int i = 0; i < len; i++) cf_mem[base + i] = 8'h00;
				for (int i = 0; i < bpc; i++) cf_mem[off + i] = rx_mem[off + i];
			end
		end
		seen[kind] |= flag;
		if (seen[kind] != full && total > 4) begin
			if (wide) begin
				for (int i = 0; i + 1 < len; i += 2) begin
					if (cf_mem[base + i] != 0) continue;
					ch = cf_mem[base + i + 1];
					if (ch == 0) break;
					if (ch == CHAR_CR) begin seen[kind] = full; break; end
				end
			end else begin
				for (int i = 0; i < len; i++) begin
					ch = cf_mem[base + i];
					if (ch == 0) break;
					if (ch == CHAR_CR) begin seen[kind] = full; break; end
				end
			end
		end
		if (seen[kind] == full) begin
			pairs = len / 2;
			if (wide)
				empty = cf_mem[base] == 0 &&
					(cf_mem[base + 1] == 0 || cf_mem[base + 1] == CHAR_CR);
			else
				empty = cf_mem[base] == 0 || cf_mem[base] == CHAR_CR;
			if (empty) begin
				rows_due.push_back(mk_row(STAT_EMPTY, 2'(kind), 5'(seg), 16'd0, 6'd0, 1'b1));
				return;
			end
			for (int i = 0; i < pairs; i++)
				rows_due.push_back(mk_row(STAT_COMPLETE, 2'(kind), 5'(seg),
					{cf_mem[base + 2 * i], cf_mem[base + 2 * i + 1]}, 6'(i), i + 1 == pairs));
			return;
		end
		rows_due.push_back(mk_row(restarted ? STAT_RESTARTED : STAT_CONFIRMED,
			2'(kind), 5'(seg), 16'd0, 6'd0, 1'b1));
	endtask

	task automatic decode_group(logic [15:0] b, logic [15:0] c, logic [15:0] d);
		logic [3:0] gt, agt;
		logic vb;
		gt = b[15:12];
		vb = b[11];
		agt = b[4:1];
		if (gt == GT_NAME) begin
			assemble_segment(KIND_NAME, BASE_NAME, b[1:0], 2, 4, 0, d[15:8], d[7:0],
				8'd0, 8'd0);
			return;
		end
		if (gt == GT_RT) begin
			if (vb)
				assemble_segment(KIND_RT, BASE_RT, b[3:0], 2, 16, 0,
					d[15:8], d[7:0], 8'd0, 8'd0);
			else
				assemble_segment(KIND_RT, BASE_RT, b[3:0], 4, 16, 0,
					c[15:8], c[7:0], d[15:8], d[7:0]);
			return;
		end
		if (gt == GT_ODA && !vb) begin
			if (d == AID_TAGGING && tag_gt != agt) begin
				tag_gt = agt;
				tag_tmpl = c[12];
				rows_due.push_back(mk_row(STAT_APP_REG, KIND_NAME, 5'd0, 16'd0, 6'd0, 1'b1));
				return;
			end
			if (d == AID_ENHANCED && ert_gt != agt) begin
				ert_gt = agt;
				ert_table = c[4:2];
				ert_utf8 = c[0];
				rows_due.push_back(mk_row(STAT_APP_REG, KIND_NAME, 5'd0, 16'd0, 6'd0, 1'b1));
				return;
			end
		end else if (gt == GT_TN && !vb) begin
			assemble_segment(KIND_TN, BASE_TN, b[0], 4, 2, 0,
				c[15:8], c[7:0], d[15:8], d[7:0]);
			return;
		end else if (gt == tag_gt && !vb && !tag_tmpl) begin
		end else if (gt == ert_gt && !vb && ert_table == 0) begin
			assemble_segment(KIND_ERT, BASE_ERT, b[4:0], 4, 32, !ert_utf8,
				c[15:8], c[7:0], d[15:8], d[7:0]);
			return;
		end
		rows_due.push_back(mk_row(STAT_IGNORED, KIND_NAME, 5'd0, 16'd0, 6'd0, 1'b1));
	endtask

	always @(posedge clk or negedge arst_n) begin
		row_t exp_row;
		if (!arst_n) begin
			for (int i = 0; i < 208; i++) begin
				rx_mem[i] = 0;
				cf_mem[i] = 0;
			end
			for (int k = 0; k < 4; k++) seen[k] = 0;
			tag_gt = 0; tag_tmpl = 0; ert_gt = 0; ert_table = 0; ert_utf8 = 0;
			rows_due.delete();
			fail_count = 0;
		end else begin
			if (grp_valid && !grp_stall)
				decode_group(block_b, block_c, block_d);
			if (res_valid && !res_stall) begin
				if (rows_due.size() == 0) begin
					$error("result row with nothing expected");
					fail_count++;
				end else begin
					exp_row = rows_due.pop_front();
					if (status !== exp_row.st) begin
						$error("status exp %0d got %0d", exp_row.st, status); fail_count++;
					end
					if (text_kind !== exp_row.kind) begin
						$error("text_kind exp %0d got %0d", exp_row.kind, text_kind);
						fail_count++;
					end
					if (segment_number !== exp_row.seg) begin
						$error("segment_number exp %0d got %0d", exp_row.seg,
							segment_number);
						fail_count++;
					end
					if (text_pair !== exp_row.pair) begin
						$error("text_pair exp %h got %h", exp_row.pair, text_pair);
						fail_count++;
					end
					if (pair_index !== exp_row.idx) begin
						$error("pair_index exp %0d got %0d", exp_row.idx, pair_index);
						fail_count++;
					end
					if (last !== exp_row.lst) begin
						$error("last exp %0d got %0d", exp_row.lst, last); fail_count++;
					end
				end
			end
		end
	end

endmodule

@@ tb/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Drives RDS groups into the text assembler: directed corner cases, then
// random segment pairs for all four texts with announcements and noise,
// under random idling on both sides; the checker judges every result row.
// ----------------------------------------------------------------------------
module tb
	import rgta_pkg::*;
();

	localparam int CYCLE_LIMIT = 2_000_000;

	logic        clk;
	logic        arst_n;
	logic        grp_valid;
	logic        grp_stall;
	logic [15:0] block_b;
	logic [15:0] block_c;
	logic [15:0] block_d;
	logic        res_valid;
	logic        res_stall;
	logic [2:0]  status;
	logic [1:0]  text_kind;
	logic [4:0]  segment_number;
	logic [15:0] text_pair;
	logic [5:0]  pair_index;
	logic        last;
	int          fail_count;
	int          rows_pending;
	int          cycle_count = 0;
	bit          calm;
	bit          hold_off;

	rds_group_text_assembler u_dut (.*);

	rgta_checker u_chk (.*);

	initial clk = 0;
	always #1 clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	// receiver: random stalls, none while calm, a long hold-off on request
	always @(negedge clk or negedge arst_n) begin
		if (!arst_n)
			res_stall <= 0;
		else
			res_stall <= hold_off || (!calm && $urandom_range(0, 99) < 15);
	end

	// called at a falling edge; returns at the falling edge after acceptance
	task automatic send(logic [15:0] b, logic [15:0] c, logic [15:0] d);
		while (!calm && $urandom_range(0, 99) < 15) begin
			grp_valid <= 0;
			@(negedge clk);
		end
		grp_valid <= 1;
		block_b <= b;
		block_c <= c;
		block_d <= d;
		while (grp_stall) @(negedge clk);
		@(negedge clk);
	endtask

	task automatic send_twice(logic [15:0] b, logic [15:0] c, logic [15:0] d);
		send(b, c, d);
		send(b, c, d);
	endtask

	function automatic logic [7:0] pick_char();
		int r;
		r = $urandom_range(0, 99);
		if (r < 4) return 8'h00;
		if (r < 8) return CHAR_CR;
		if (r < 14) return 8'($urandom_range(0, 255));
		return 8'($urandom_range(8'h20, 8'h7e));
	endfunction

	function automatic logic [15:0] char_word();
		return {pick_char(), pick_char()};
	endfunction

	task automatic drain();
		grp_valid <= 0;
		while (rows_pending != 0) @(negedge clk);
	endtask

	initial begin
		logic [15:0] b, c, d;
		int sel, n;
		grp_valid = 0;
		block_b = 0; block_c = 0; block_d = 0;
		calm = 0; hold_off = 0;
		arst_n = 0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1;

		// directed
		send(16'h0000, 16'h0000, 16'h4142);
		send(16'h0000, 16'h0000, 16'h4142);
		send(16'h0000, 16'h0000, 16'h4142);
		send_twice(16'h0001, 16'hffff, 16'h4344);
		send_twice(16'h0002, 16'h0000, 16'h4546);
		send_twice(16'h0003, 16'h0000, 16'h4748);
		send_twice(16'h0000, 16'h0000, 16'h5a5a);
		send_twice(16'h2000, 16'h4849, 16'h0d00);
		send_twice(16'h2800, 16'h0000, 16'h0d20);
		send_twice(16'ha000, 16'h5459, 16'h5045);
		send_twice(16'ha7ff, 16'hffff, 16'hffff);
		send(16'h3016, 16'h0000, AID_ENHANCED);
		send(16'h3010, 16'h1000, AID_TAGGING);
		send(16'h3810, 16'h0000, AID_TAGGING);
		send_twice(16'hb000, 16'h0041, 16'h000d);
		send(16'hb800, 16'h0041, 16'h000d);
		send(16'h8123, 16'h5555, 16'haaaa);
		drain();

		// random, partly in calm stretches
		for (int it = 0; it < 250; it++) begin
			calm = (it >= 80 && it < 130);
			if (it == 160) begin
				drain();
				fork
					begin
						hold_off = 1;
						repeat (800) @(negedge clk);
						hold_off = 0;
					end
				join_none
			end
			if (it == 215) drain();
			sel = $urandom_range(0, 99);
			c = char_word();
			d = char_word();
			b = 16'($urandom);
			if (sel < 12) begin
				b[15:12] = GT_NAME;
				send_twice(b, 16'($urandom), d);
			end else if (sel < 40) begin
				b[15:12] = GT_RT;
				send_twice(b, c, d);
			end else if (sel < 52) begin
				b[15:12] = GT_TN;
				b[11] = 0;
				send_twice(b, c, d);
			end else if (sel < 58) begin
				b[15:12] = GT_ODA;
				b[11] = $urandom_range(0, 5) == 0;
				b[4:1] = $urandom_range(0, 4) == 0 ? 4'($urandom) : 4'd11;
				c = 16'($urandom);
				if ($urandom_range(0, 2) != 0) c[4:2] = 0;
				n = $urandom_range(0, 3);
				d = n == 0 ? AID_TAGGING : n == 3 ? 16'($urandom) : AID_ENHANCED;
				send(b, c, d);
			end else if (sel < 85) begin
				b[15:12] = 4'd11;
				b[11] = $urandom_range(0, 7) == 0;
				send_twice(b, c, d);
			end else begin
				send(b, 16'($urandom), 16'($urandom));
			end
		end
		calm = 0;
		drain();
		repeat (1000) @(negedge clk);
		if (fail_count == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

@@ sim.f @@
hw/rtl/rgta_pkg.sv
hw/rtl/rgta_ram.sv
hw/rtl/rds_group_text_assembler.sv
tb/rgta_checker.sv
tb/tb.sv
